// ===== sv/gcb_pkg.sv =====
// package for the great circle bearing pipeline: constants and tables
package gcb_pkg;

    localparam int ANGLE_BITS_DEF    = 32;
    localparam int OUT_FRAC_BITS_DEF = 13;
    localparam int HEADING_W         = 16;
    localparam int ITERS             = 30;
    // cordic datapath width: Q2.30 values plus headroom
    localparam int DW                = 36;
    // angle accumulator width
    localparam int ZW                = 34;

    localparam logic signed [DW-1:0] GAIN_Q30 = 36'sd652032874;
    localparam logic signed [ZW-1:0] QUARTER  = 34'sd1073741824;
    localparam logic signed [ZW-1:0] HALF     = 34'sd2147483648;
    localparam logic signed [31:0]   PI_Q29   = 32'sd1686629713;

    // arctangent table in binary-angle units
    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            r = '0;
            unique case (i)
                5'd0:  r = 34'sd536870912;
                5'd1:  r = 34'sd316933406;
                5'd2:  r = 34'sd167458907;
                5'd3:  r = 34'sd85004756;
                5'd4:  r = 34'sd42667331;
                5'd5:  r = 34'sd21354465;
                5'd6:  r = 34'sd10679838;
                5'd7:  r = 34'sd5340245;
                5'd8:  r = 34'sd2670163;
                5'd9:  r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                5'd24: r = 34'sd41;
                5'd25: r = 34'sd20;
                5'd26: r = 34'sd10;
                5'd27: r = 34'sd5;
                5'd28: r = 34'sd3;
                5'd29: r = 34'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/gcb_if.sv =====
// valid/ready channel interfaces for the bearing block
interface gcb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] lat_from;
    logic [31:0] lon_from;
    logic [31:0] lat_to;
    logic [31:0] lon_to;
    modport source (output valid, lat_from, lon_from, lat_to, lon_to, input ready);
    modport sink   (input valid, lat_from, lon_from, lat_to, lon_to, output ready);
endinterface

interface gcb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading;
    modport source (output valid, heading, input ready);
    modport sink   (input valid, heading, output ready);
endinterface

// ===== sv/great_circle_bearing.sv =====
// great circle initial bearing: pipelined cordic sin/cos, products, cordic atan2
//
// usage: waypoint pairs arrive on the in channel (lat_from, lon_from, lat_to,
// lon_to as 32-bit binary angles) and bearings leave on the out channel as
// signed radians with OUT_FRAC_BITS fraction bits (Q3.13 by default).
// throughput: one transaction per cycle in steady state, while the receiver takes results.
// pipeline: 68 register stages from input to heading: one input stage,
// 30 rotation cordic stages, a sign-fix stage, three product stages, a
// fold stage, 30 vectoring cordic stages, a scaling multiply stage and
// the output register.
// the pipeline is one long shift chain with a valid bit per stage; it
// advances whenever the output register is empty or being drained, so a
// stalled receiver freezes every stage and nothing is lost or repeated.
// in.ready is low only while the output holds a result that is not taken.
// reset clears all valid bits; data registers are not reset.
module great_circle_bearing #(
    parameter int ANGLE_BITS    = gcb_pkg::ANGLE_BITS_DEF,
    parameter int OUT_FRAC_BITS = gcb_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    gcb_in_if.sink    in,
    gcb_out_if.source out
);
    import gcb_pkg::*;

    localparam int NST   = 2 * ITERS + 8;
    localparam int SHIFT = 60 - OUT_FRAC_BITS;
    localparam logic [31:0] KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    typedef logic signed [DW-1:0] d_t;
    typedef logic signed [ZW-1:0] z_t;

    // global advance
    logic adv;
    assign adv      = !out.valid || out.ready;
    assign in.ready = adv;

    logic [NST-1:0] v_reg;

    // rotation cordic, three lanes, one iteration per stage
    d_t   rx_reg [ITERS+1][3];
    d_t   ry_reg [ITERS+1][3];
    z_t   rz_reg [ITERS+1][3];
    logic rf_reg [ITERS+1][3];

    // stage 0: mask, dlon, quadrant fold for the three angles
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [31:0] l1, l2, o1, o2, dl;
            z_t ang [3];
            l1 = $signed(in.lat_from & KEEP);
            o1 = $signed(in.lon_from & KEEP);
            l2 = $signed(in.lat_to & KEEP);
            o2 = $signed(in.lon_to & KEEP);
            dl = o2 - o1;
            ang[0] = z_t'(l1);
            ang[1] = z_t'(l2);
            ang[2] = z_t'(dl);
            for (int k = 0; k < 3; k++)
            begin
                rx_reg[0][k] <= GAIN_Q30;
                ry_reg[0][k] <= '0;
                if (ang[k] > QUARTER)
                begin
                    rz_reg[0][k] <= ang[k] - HALF; rf_reg[0][k] <= 1'b1;
                end
                else if (ang[k] < -QUARTER)
                begin
                    rz_reg[0][k] <= ang[k] + HALF; rf_reg[0][k] <= 1'b1;
                end
                else
                begin
                    rz_reg[0][k] <= ang[k]; rf_reg[0][k] <= 1'b0;
                end
            end
        end
    end

    for (genvar i = 0; i < ITERS; i++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (rz_reg[i][k] >= 0)
                    begin
                        rx_reg[i+1][k] <= rx_reg[i][k] - (ry_reg[i][k] >>> i);
                        ry_reg[i+1][k] <= ry_reg[i][k] + (rx_reg[i][k] >>> i);
                        rz_reg[i+1][k] <= rz_reg[i][k] - atan_tab(5'(i));
                    end
                    else
                    begin
                        rx_reg[i+1][k] <= rx_reg[i][k] + (ry_reg[i][k] >>> i);
                        ry_reg[i+1][k] <= ry_reg[i][k] - (rx_reg[i][k] >>> i);
                        rz_reg[i+1][k] <= rz_reg[i][k] + atan_tab(5'(i));
                    end
                    rf_reg[i+1][k] <= rf_reg[i][k];
                end
            end
        end
    end

    // apply fold flip: sin/cos of lat1, lat2, dlon
    d_t s_reg [3];
    d_t c_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s_reg[k] <= rf_reg[ITERS][k] ? -ry_reg[ITERS][k] : ry_reg[ITERS][k];
                c_reg[k] <= rf_reg[ITERS][k] ? -rx_reg[ITERS][k] : rx_reg[ITERS][k];
            end
        end
    end

    // products: num = sd*c2, t = s1*c2, u = c1*s2, then t*cd
    d_t num_reg, t_reg, u_reg, cd_reg;
    d_t num2_reg, u2_reg, tc_reg;
    d_t num3_reg, den_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [2*DW-1:0] p0, p1, p2, p3;
            p0 = s_reg[2] * c_reg[1];
            p1 = s_reg[0] * c_reg[1];
            p2 = c_reg[0] * s_reg[1];
            num_reg <= d_t'(p0 >>> 30);
            t_reg   <= d_t'(p1 >>> 30);
            u_reg   <= d_t'(p2 >>> 30);
            cd_reg  <= c_reg[2];
            p3 = t_reg * cd_reg;
            num2_reg <= num_reg;
            u2_reg   <= u_reg;
            tc_reg   <= d_t'(p3 >>> 30);
            num3_reg <= num2_reg;
            den_reg  <= u2_reg - tc_reg;
        end
    end

    // vectoring cordic prep: half-plane fold, zero-vector flag
    d_t   vx_reg [ITERS+1];
    d_t   vy_reg [ITERS+1];
    z_t   vz_reg [ITERS+1];
    logic vzero_reg [ITERS+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vzero_reg[0] <= (num3_reg == '0) && (den_reg == '0);
            if (den_reg < 0)
            begin
                vx_reg[0] <= -den_reg; vy_reg[0] <= -num3_reg; vz_reg[0] <= HALF;
            end
            else
            begin
                vx_reg[0] <= den_reg; vy_reg[0] <= num3_reg; vz_reg[0] <= '0;
            end
        end
    end
    for (genvar i = 0; i < ITERS; i++)
    begin : g_vec
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (vy_reg[i] > 0)
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + atan_tab(5'(i));
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - atan_tab(5'(i));
                end
                vzero_reg[i+1] <= vzero_reg[i];
            end
        end
    end

    // scale binary angle to radians with rounding, fix minus pi
    localparam logic signed [63:0] PI_FULL = 64'(signed'(HALF)) * 64'(PI_Q29);
    localparam logic signed [63:0] PI_OUT  =
        (PI_FULL + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
    logic signed [63:0] prod_reg;
    logic               pz_reg;
    logic [15:0]        heading_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [31:0] zw;
            logic signed [63:0] h;
            zw = vz_reg[ITERS][31:0];
            prod_reg <= 64'(zw) * 64'(PI_Q29);
            pz_reg   <= vzero_reg[ITERS];
            h = (prod_reg + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
            if (pz_reg)
                heading_reg <= '0;
            else if (h == -PI_OUT)
                heading_reg <= PI_OUT[15:0];
            else
                heading_reg <= h[15:0];
        end
    end

    // valid chain travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NST-2:0], in.valid};
    end

    assign out.valid   = v_reg[NST-1];
    assign out.heading = heading_reg;

endmodule

// ===== sv/gcb_checker.sv =====
// port-level checker for the bearing block, bound to the top level
module gcb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] heading
);
    // input is refused only while a result waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in.ready low without output stall");
    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heading))
        else $error("output changed under stall");
    // heading never reads as minus pi
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading != 16'h9B78)
        else $error("heading is minus pi");
endmodule

bind great_circle_bearing gcb_checker u_gcb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .heading   (out.heading)
);
